@@ design/lpp_pkg.sv @@
// Shared constants, codes and bus types for the layered point pick block.
// Used by lpp_cell and layered_point_pick_core; depends on nothing.
`timescale 1ns / 1ps

package lpp_pkg;

  // table size and field widths
  localparam int ENTRIES     = 64;
  localparam int COORD_BITS  = 16;
  localparam int OP_BITS     = 2;
  localparam int SLOT_BITS   = 6;
  localparam int GROUP_BITS  = 8;
  localparam int KIND_BITS   = 2;
  localparam int ID_BITS     = 16;
  localparam int LAYER_BITS  = 16;
  localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MATCH_BITS  = (IDX_BITS > SLOT_BITS) ? IDX_BITS : SLOT_BITS;

  // opcodes
  localparam logic [OP_BITS-1:0] OP_WRITE    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_PICK_ALL = 2'd1;
  localparam logic [OP_BITS-1:0] OP_PICK_HOT = 2'd2;

  // entry kinds
  localparam logic [KIND_BITS-1:0] KIND_HOTSPOT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SPRITE  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_BITMAP  = 2'd2;

  // write bus broadcast to every cell
  typedef struct packed {
    logic                         en;
    logic [SLOT_BITS-1:0]         slot;
    logic [GROUP_BITS-1:0]        group;
    logic [KIND_BITS-1:0]         kind;
    logic [ID_BITS-1:0]           item_id;
    logic signed [LAYER_BITS-1:0] layer;
    logic                         active;
    logic signed [COORD_BITS-1:0] x_left;
    logic signed [COORD_BITS-1:0] y_top;
    logic signed [COORD_BITS-1:0] x_right;
    logic signed [COORD_BITS-1:0] y_bottom;
  } wr_t;

  // pick token handed from cell to cell, carrying the best entry so far
  typedef struct packed {
    logic                         valid;
    logic                         hot_only;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         found;
    logic signed [LAYER_BITS-1:0] best_layer;
    logic [GROUP_BITS-1:0]        group;
    logic [KIND_BITS-1:0]         kind;
    logic [ID_BITS-1:0]           id;
  } tok_t;

endpackage

@@ design/layered_point_pick_core.sv @@
// Top level of the layered point pick block: command port, cell chain, result register.
// Depends on lpp_pkg and lpp_cell.
//
//   channel  | handshake         | fields
//   ---------+-------------------+--------------------------------------------
//   input    | start / busy      | in_opcode in_slot in_group in_kind in_item_id
//            |                   | in_layer in_active in_x_left in_y_top
//            |                   | in_x_right in_y_bottom
//   result   | out_valid strobe  | out_hit out_hit_group out_hit_kind out_hit_id
//
// A pick travels down a chain of ENTRIES cells, one cell per cycle, so its result
// strobes after its token leaves the last cell, and busy is high from acceptance until then;
// the next item is taken at the edge that ends the strobe.
// A write or an unused opcode is not busy and strobes its result the next cycle.
// Reset clears every active flag at once; the table is empty with no clear sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module layered_point_pick_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [lpp_pkg::OP_BITS-1:0]           in_opcode,
  input  logic [lpp_pkg::SLOT_BITS-1:0]         in_slot,
  input  logic [lpp_pkg::GROUP_BITS-1:0]        in_group,
  input  logic [lpp_pkg::KIND_BITS-1:0]         in_kind,
  input  logic [lpp_pkg::ID_BITS-1:0]           in_item_id,
  input  logic signed [lpp_pkg::LAYER_BITS-1:0] in_layer,
  input  logic                                  in_active,
  input  logic signed [lpp_pkg::COORD_BITS-1:0] in_x_left,
  input  logic signed [lpp_pkg::COORD_BITS-1:0] in_y_top,
  input  logic signed [lpp_pkg::COORD_BITS-1:0] in_x_right,
  input  logic signed [lpp_pkg::COORD_BITS-1:0] in_y_bottom,
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic [lpp_pkg::GROUP_BITS-1:0]        out_hit_group,
  output logic [lpp_pkg::KIND_BITS-1:0]         out_hit_kind,
  output logic [lpp_pkg::ID_BITS-1:0]           out_hit_id
);

  logic busy_r;
  logic busy_nxt;
  logic acc;
  logic pick_acc;
  logic is_pick;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            out_hit_r;
  logic [lpp_pkg::GROUP_BITS-1:0]  out_hit_group_r;
  logic [lpp_pkg::KIND_BITS-1:0]   out_hit_kind_r;
  logic [lpp_pkg::ID_BITS-1:0]     out_hit_id_r;

  lpp_pkg::wr_t  wr;
  lpp_pkg::tok_t chain [lpp_pkg::ENTRIES+1];
  logic [lpp_pkg::ENTRIES-1:0] tok_vld;
  lpp_pkg::tok_t tok_end;

  // command decode
  assign acc      = start && !busy_r;
  assign is_pick  = (in_opcode == lpp_pkg::OP_PICK_ALL) ||
                    (in_opcode == lpp_pkg::OP_PICK_HOT);
  assign pick_acc = acc && is_pick;

  // write bus to all cells
  always_comb begin
    wr.en       = acc && (in_opcode == lpp_pkg::OP_WRITE);
    wr.slot     = in_slot;
    wr.group    = in_group;
    wr.kind     = in_kind;
    wr.item_id  = in_item_id;
    wr.layer    = in_layer;
    wr.active   = in_active;
    wr.x_left   = in_x_left;
    wr.y_top    = in_y_top;
    wr.x_right  = in_x_right;
    wr.y_bottom = in_y_bottom;
  end

  // fresh pick token enters the head of the chain
  always_comb begin
    chain[0].valid      = pick_acc;
    chain[0].hot_only   = (in_opcode == lpp_pkg::OP_PICK_HOT);
    chain[0].x          = in_x_left;
    chain[0].y          = in_y_top;
    chain[0].found      = 1'b0;
    chain[0].best_layer = '0;
    chain[0].group      = '0;
    chain[0].kind       = lpp_pkg::KIND_HOTSPOT;
    chain[0].id         = '0;
  end

  // cell chain, slot 0 first
  for (genvar i = 0; i < lpp_pkg::ENTRIES; i++) begin : g_cell
    lpp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lpp_pkg::IDX_BITS'(i)),
      .wr       (wr),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );
    assign tok_vld[i] = chain[i+1].valid;
  end

  assign tok_end = chain[lpp_pkg::ENTRIES];

  // busy from pick acceptance until the token leaves the last cell
  always_comb begin
    busy_nxt = busy_r;
    if (pick_acc) begin
      busy_nxt = 1'b1;
    end else if (tok_end.valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // result strobe
  assign out_valid_nxt = tok_end.valid || (acc && !is_pick);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: finished pick, or all zero for other items
  always_ff @(posedge clk) begin
    if (tok_end.valid) begin
      out_hit_r       <= tok_end.found;
      out_hit_group_r <= tok_end.group;
      out_hit_kind_r  <= tok_end.kind;
      out_hit_id_r    <= tok_end.id;
    end else if (acc && !is_pick) begin
      out_hit_r       <= 1'b0;
      out_hit_group_r <= '0;
      out_hit_kind_r  <= lpp_pkg::KIND_HOTSPOT;
      out_hit_id_r    <= '0;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_group = out_hit_group_r;
  assign out_hit_kind  = out_hit_kind_r;
  assign out_hit_id    = out_hit_id_r;

  // at most one token in the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one pick token in the chain");

  // busy tracks exactly the presence of a token
  a_busy_token: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (|tok_vld))
    else $error("busy does not match chain occupancy");

  // no result strobe while a pick is still travelling
  a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result strobe during a pick");

  // a write gets a miss result the next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (out_valid_r && !out_hit_r))
    else $error("write item result missing or marked as hit");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |->
      (out_hit_group_r == '0 && out_hit_id_r == '0 &&
       out_hit_kind_r == lpp_pkg::KIND_HOTSPOT))
    else $error("miss result with nonzero fields");

endmodule

@@ design/lpp_cell.sv @@
// One table cell: holds a single rectangle entry and updates the passing pick token.
// Depends on lpp_pkg for widths, kind codes and the wr_t / tok_t bus types.
`timescale 1ns / 1ps

module lpp_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lpp_pkg::IDX_BITS-1:0]      cell_idx,
  input  lpp_pkg::wr_t                      wr,
  input  lpp_pkg::tok_t                     tok_i,
  output lpp_pkg::tok_t                     tok_o
);

  // stored entry
  logic                                 active_r;
  logic [lpp_pkg::GROUP_BITS-1:0]       group_r;
  logic [lpp_pkg::KIND_BITS-1:0]        kind_r;
  logic [lpp_pkg::ID_BITS-1:0]          id_r;
  logic signed [lpp_pkg::LAYER_BITS-1:0] layer_r;
  logic signed [lpp_pkg::COORD_BITS-1:0] left_r;
  logic signed [lpp_pkg::COORD_BITS-1:0] top_r;
  logic signed [lpp_pkg::COORD_BITS-1:0] right_r;
  logic signed [lpp_pkg::COORD_BITS-1:0] bottom_r;

  lpp_pkg::tok_t tok_r;
  lpp_pkg::tok_t tok_nxt;

  logic wr_hit;
  logic in_rect;
  logic eligible;
  logic take;

  // slot decode against this cell's position
  assign wr_hit = wr.en &&
    (lpp_pkg::MATCH_BITS'(wr.slot) == lpp_pkg::MATCH_BITS'(cell_idx));

  // active flag clears at reset so the whole table reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (wr_hit) begin
      active_r <= wr.active;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      group_r  <= wr.group;
      kind_r   <= wr.kind;
      id_r     <= wr.item_id;
      layer_r  <= wr.layer;
      left_r   <= wr.x_left;
      top_r    <= wr.y_top;
      right_r  <= wr.x_right;
      bottom_r <= wr.y_bottom;
    end
  end

  // containment: bitmaps drop the right and bottom edges
  always_comb begin
    unique case (kind_r)
      lpp_pkg::KIND_HOTSPOT, lpp_pkg::KIND_SPRITE: begin
        in_rect = ($signed(tok_i.x) >= $signed(left_r)) &&
                  ($signed(tok_i.x) <= $signed(right_r)) &&
                  ($signed(tok_i.y) >= $signed(top_r)) &&
                  ($signed(tok_i.y) <= $signed(bottom_r));
      end
      lpp_pkg::KIND_BITMAP: begin
        in_rect = ($signed(tok_i.x) >= $signed(left_r)) &&
                  ($signed(tok_i.x) <  $signed(right_r)) &&
                  ($signed(tok_i.y) >= $signed(top_r)) &&
                  ($signed(tok_i.y) <  $signed(bottom_r));
      end
      default: begin
        in_rect = 1'b0;
      end
    endcase
  end

  // strictly higher layer replaces, so ties stay with the lower slot
  assign eligible = tok_i.valid && active_r && in_rect &&
                    (!tok_i.hot_only || (kind_r == lpp_pkg::KIND_HOTSPOT));
  assign take = eligible &&
                (!tok_i.found || ($signed(layer_r) > $signed(tok_i.best_layer)));

  always_comb begin
    tok_nxt = tok_i;
    if (take) begin
      tok_nxt.found      = 1'b1;
      tok_nxt.best_layer = layer_r;
      tok_nxt.group      = group_r;
      tok_nxt.kind       = kind_r;
      tok_nxt.id         = id_r;
    end
  end

  // token register, valid cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.hot_only   <= tok_nxt.hot_only;
    tok_r.x          <= tok_nxt.x;
    tok_r.y          <= tok_nxt.y;
    tok_r.found      <= tok_nxt.found;
    tok_r.best_layer <= tok_nxt.best_layer;
    tok_r.group      <= tok_nxt.group;
    tok_r.kind       <= tok_nxt.kind;
    tok_r.id         <= tok_nxt.id;
  end

  assign tok_o = tok_r;

endmodule

@@ bench/layered_point_pick_core_tb.sv @@
// Self-checking bench for layered_point_pick_core: directed table, then random items.
// Depends on lpp_pkg and the design; expected hits come from a table mirror kept in this file.
`timescale 1ns / 1ps

module layered_point_pick_core_tb;

  // codes the package leaves unnamed
  localparam logic [lpp_pkg::OP_BITS-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [lpp_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  localparam int RAND_ITEMS   = 1200;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = lpp_pkg::ENTRIES + 4;
  localparam int MAX_REPORTS  = 100;

  // one command item as driven on the input ports
  typedef struct packed {
    logic [lpp_pkg::OP_BITS-1:0]           op;
    logic [lpp_pkg::SLOT_BITS-1:0]         slot;
    logic [lpp_pkg::GROUP_BITS-1:0]        group;
    logic [lpp_pkg::KIND_BITS-1:0]         kind;
    logic [lpp_pkg::ID_BITS-1:0]           id;
    logic signed [lpp_pkg::LAYER_BITS-1:0] layer;
    logic                                  active;
    logic signed [lpp_pkg::COORD_BITS-1:0] x_left;
    logic signed [lpp_pkg::COORD_BITS-1:0] y_top;
    logic signed [lpp_pkg::COORD_BITS-1:0] x_right;
    logic signed [lpp_pkg::COORD_BITS-1:0] y_bottom;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic                           hit;
    logic [lpp_pkg::GROUP_BITS-1:0] group;
    logic [lpp_pkg::KIND_BITS-1:0]  kind;
    logic [lpp_pkg::ID_BITS-1:0]    id;
  } hit_t;

  // directed row: item plus an optional hand-written result
  typedef struct {
    cmd_t c;
    bit   fixed;
    hit_t res;
  } row_t;

  localparam hit_t MISS = '0;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  cmd_t drv;
  bit   drv_fixed;
  hit_t drv_res;

  logic                           out_valid;
  logic                           out_hit;
  logic [lpp_pkg::GROUP_BITS-1:0] out_hit_group;
  logic [lpp_pkg::KIND_BITS-1:0]  out_hit_kind;
  logic [lpp_pkg::ID_BITS-1:0]    out_hit_id;

  // mirror of the rectangle table
  logic signed [lpp_pkg::COORD_BITS-1:0] tbl_left   [lpp_pkg::ENTRIES] = '{default: '0};
  logic signed [lpp_pkg::COORD_BITS-1:0] tbl_top    [lpp_pkg::ENTRIES] = '{default: '0};
  logic signed [lpp_pkg::COORD_BITS-1:0] tbl_right  [lpp_pkg::ENTRIES] = '{default: '0};
  logic signed [lpp_pkg::COORD_BITS-1:0] tbl_bottom [lpp_pkg::ENTRIES] = '{default: '0};
  logic [lpp_pkg::GROUP_BITS-1:0]        tbl_group  [lpp_pkg::ENTRIES] = '{default: '0};
  logic [lpp_pkg::KIND_BITS-1:0]         tbl_kind   [lpp_pkg::ENTRIES] = '{default: '0};
  logic [lpp_pkg::ID_BITS-1:0]           tbl_id     [lpp_pkg::ENTRIES] = '{default: '0};
  logic signed [lpp_pkg::LAYER_BITS-1:0] tbl_layer  [lpp_pkg::ENTRIES] = '{default: '0};
  bit                                    tbl_active [lpp_pkg::ENTRIES] = '{default: 1'b0};

  hit_t expected_hits [$];
  row_t directed [$];
  int   mismatches  = 0;
  int   n_results   = 0;
  int   idle_cycles = 0;

  layered_point_pick_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (drv.op),
    .in_slot       (drv.slot),
    .in_group      (drv.group),
    .in_kind       (drv.kind),
    .in_item_id    (drv.id),
    .in_layer      (drv.layer),
    .in_active     (drv.active),
    .in_x_left     (drv.x_left),
    .in_y_top      (drv.y_top),
    .in_x_right    (drv.x_right),
    .in_y_bottom   (drv.y_bottom),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_hit_group (out_hit_group),
    .out_hit_kind  (out_hit_kind),
    .out_hit_id    (out_hit_id)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // apply one item to the mirror table and work out its result
  function automatic hit_t step_table(cmd_t c);
    hit_t r;
    bit found;
    bit covers;
    logic signed [lpp_pkg::LAYER_BITS-1:0] best;
    logic signed [lpp_pkg::COORD_BITS-1:0] px;
    logic signed [lpp_pkg::COORD_BITS-1:0] py;
    r = MISS;
    found = 1'b0;
    best = '0;
    px = c.x_left;
    py = c.y_top;
    if (c.op == lpp_pkg::OP_WRITE) begin
      if (int'(c.slot) < lpp_pkg::ENTRIES) begin
        tbl_left[c.slot]   = c.x_left;
        tbl_top[c.slot]    = c.y_top;
        tbl_right[c.slot]  = c.x_right;
        tbl_bottom[c.slot] = c.y_bottom;
        tbl_group[c.slot]  = c.group;
        tbl_kind[c.slot]   = c.kind;
        tbl_id[c.slot]     = c.id;
        tbl_layer[c.slot]  = c.layer;
        tbl_active[c.slot] = c.active;
      end
    end else if (c.op == lpp_pkg::OP_PICK_ALL || c.op == lpp_pkg::OP_PICK_HOT) begin
      for (int i = 0; i < lpp_pkg::ENTRIES; i++) begin
        // hotspots and sprites take all edges, bitmaps drop right and bottom
        case (tbl_kind[i])
          lpp_pkg::KIND_HOTSPOT, lpp_pkg::KIND_SPRITE: begin
            covers = px >= tbl_left[i] && px <= tbl_right[i] &&
                     py >= tbl_top[i] && py <= tbl_bottom[i];
          end
          lpp_pkg::KIND_BITMAP: begin
            covers = px >= tbl_left[i] && px < tbl_right[i] &&
                     py >= tbl_top[i] && py < tbl_bottom[i];
          end
          default: begin
            covers = 1'b0;
          end
        endcase
        if (c.op == lpp_pkg::OP_PICK_HOT && tbl_kind[i] != lpp_pkg::KIND_HOTSPOT) begin
          covers = 1'b0;
        end
        // strictly higher layer wins, so ties keep the lowest slot
        if (tbl_active[i] && covers && (!found || tbl_layer[i] > best)) begin
          found   = 1'b1;
          best    = tbl_layer[i];
          r.hit   = 1'b1;
          r.group = tbl_group[i];
          r.kind  = tbl_kind[i];
          r.id    = tbl_id[i];
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch on result %0d: %s got 'h%0h expected 'h%0h",
               n_results, what, got, want);
    end
    mismatches++;
  endtask

  // result check first, then record the item accepted at this edge
  always @(posedge clk) begin
    hit_t want;
    hit_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("result with nothing pending, hit", int'(out_hit), 0);
        end else begin
          want = expected_hits.pop_front();
          if (out_hit !== want.hit) begin
            report_mismatch("hit", int'(out_hit), int'(want.hit));
          end
          if (out_hit_group !== want.group) begin
            report_mismatch("hit_group", int'(out_hit_group), int'(want.group));
          end
          if (out_hit_kind !== want.kind) begin
            report_mismatch("hit_kind", int'(out_hit_kind), int'(want.kind));
          end
          if (out_hit_id !== want.id) begin
            report_mismatch("hit_id", int'(out_hit_id), int'(want.id));
          end
        end
        n_results++;
      end
      if (start && !busy) begin
        pred = step_table(drv);
        expected_hits.insert(expected_hits.size(), drv_fixed ? drv_res : pred);
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic cmd_t wr(int slot, int group, logic [lpp_pkg::KIND_BITS-1:0] kind,
                              int id, logic signed [lpp_pkg::LAYER_BITS-1:0] layer,
                              bit active, int xl, int yt, int xr, int yb);
    cmd_t c;
    c = '0;
    c.op       = lpp_pkg::OP_WRITE;
    c.slot     = slot[lpp_pkg::SLOT_BITS-1:0];
    c.group    = group[lpp_pkg::GROUP_BITS-1:0];
    c.kind     = kind;
    c.id       = id[lpp_pkg::ID_BITS-1:0];
    c.layer    = layer;
    c.active   = active;
    c.x_left   = xl[lpp_pkg::COORD_BITS-1:0];
    c.y_top    = yt[lpp_pkg::COORD_BITS-1:0];
    c.x_right  = xr[lpp_pkg::COORD_BITS-1:0];
    c.y_bottom = yb[lpp_pkg::COORD_BITS-1:0];
    return c;
  endfunction

  function automatic cmd_t pk(logic [lpp_pkg::OP_BITS-1:0] op, int x, int y);
    cmd_t c;
    c = '0;
    c.op     = op;
    c.x_left = x[lpp_pkg::COORD_BITS-1:0];
    c.y_top  = y[lpp_pkg::COORD_BITS-1:0];
    return c;
  endfunction

  // mostly a small window so rectangles overlap, now and then anywhere
  function automatic logic signed [lpp_pkg::COORD_BITS-1:0] near_coord();
    int v;
    v = $urandom_range(0, 40) - 20;
    if ($urandom_range(0, 9) == 0) v = $urandom;
    return v[lpp_pkg::COORD_BITS-1:0];
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int sel;
    c.slot     = lpp_pkg::SLOT_BITS'($urandom);
    c.group    = lpp_pkg::GROUP_BITS'($urandom);
    c.kind     = lpp_pkg::KIND_BITS'($urandom_range(0, 3));
    c.id       = lpp_pkg::ID_BITS'($urandom);
    c.active   = ($urandom_range(0, 6) != 0);
    c.layer    = $urandom_range(0, 1) ? lpp_pkg::LAYER_BITS'($urandom)
                                      : lpp_pkg::LAYER_BITS'($urandom_range(0, 3));
    c.x_left   = lpp_pkg::COORD_BITS'($urandom);
    c.y_top    = lpp_pkg::COORD_BITS'($urandom);
    c.x_right  = lpp_pkg::COORD_BITS'($urandom);
    c.y_bottom = lpp_pkg::COORD_BITS'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      c.op = lpp_pkg::OP_WRITE;
      if ($urandom_range(0, 9) < 7) c.slot = lpp_pkg::SLOT_BITS'($urandom_range(0, 15));
      // small boxes, sometimes one pixel short of empty or reversed
      if ($urandom_range(0, 9) != 0) begin
        c.x_left   = near_coord();
        c.y_top    = near_coord();
        c.x_right  = c.x_left + lpp_pkg::COORD_BITS'($urandom_range(0, 12)) - 1'b1;
        c.y_bottom = c.y_top + lpp_pkg::COORD_BITS'($urandom_range(0, 12)) - 1'b1;
      end
    end else if (sel < 65) begin
      c.op     = lpp_pkg::OP_PICK_ALL;
      c.x_left = near_coord();
      c.y_top  = near_coord();
    end else if (sel < 90) begin
      c.op     = lpp_pkg::OP_PICK_HOT;
      c.x_left = near_coord();
      c.y_top  = near_coord();
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  task automatic drive_item(cmd_t c, bit fixed, hit_t res, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    drv       <= c;
    drv_fixed <= fixed;
    drv_res   <= res;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // hold off the sender until every pending result is back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(cmd_t c, bit fixed, hit_t res);
    row_t r;
    r.c     = c;
    r.fixed = fixed;
    r.res   = res;
    directed.insert(directed.size(), r);
  endtask

  initial begin
    cmd_t c;
    int counted;
    int seq;
    int gap;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    drv       <= '0;
    drv_fixed <= 1'b0;
    drv_res   <= MISS;

    // empty table, then a full-screen hotspot at the lowest layer
    add_row(pk(lpp_pkg::OP_PICK_ALL, 0, 0), 1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_HOT, -32768, 32767), 1'b1, MISS);
    add_row(wr(0, 255, lpp_pkg::KIND_HOTSPOT, 65535, 16'sh8000, 1'b1,
               -32768, -32768, 32767, 32767), 1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 32767, 32767), 1'b1,
            hit_t'{1'b1, 8'hFF, lpp_pkg::KIND_HOTSPOT, 16'hFFFF});
    add_row(pk(lpp_pkg::OP_PICK_HOT, -32768, -32768), 1'b1,
            hit_t'{1'b1, 8'hFF, lpp_pkg::KIND_HOTSPOT, 16'hFFFF});
    // bitmap on top layer: right and bottom edges are outside
    add_row(wr(63, 8'h5A, lpp_pkg::KIND_BITMAP, 16'h1234, 16'sh7FFF, 1'b1, 10, 10, 20, 20),
            1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 10, 10), 1'b0, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 20, 15), 1'b0, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 15, 20), 1'b0, MISS);
    add_row(pk(lpp_pkg::OP_PICK_HOT, 15, 15), 1'b0, MISS);
    // sprites on the same layer: tie goes to the lowest slot
    add_row(wr(5, 3, lpp_pkg::KIND_SPRITE, 5, 16'sh7FFF, 1'b1, 0, 0, 100, 100), 1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 15, 15), 1'b0, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 100, 100), 1'b0, MISS);
    add_row(wr(6, 4, lpp_pkg::KIND_SPRITE, 6, 16'sh7FFF, 1'b1, 0, 0, 100, 100), 1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 50, 50), 1'b0, MISS);
    // unused kind is stored but never hit
    add_row(wr(7, 7, KIND_UNUSED, 7, 16'sh7FFF, 1'b1, -32768, -32768, 32767, 32767), 1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, -500, -500), 1'b0, MISS);
    // reversed rectangle and inactive entry
    add_row(wr(8, 8, lpp_pkg::KIND_HOTSPOT, 8, 16'sh7FFF, 1'b1, 50, 0, 40, 10), 1'b1, MISS);
    add_row(wr(9, 9, lpp_pkg::KIND_HOTSPOT, 9, 16'sh7FFF, 1'b0, -32768, -32768, 32767, 32767),
            1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_HOT, 45, 5), 1'b0, MISS);
    // unused opcode changes nothing
    add_row(cmd_t'{OP_UNUSED, 6'h3F, 8'hFF, KIND_UNUSED, 16'hFFFF, 16'sh7FFF, 1'b1,
                   16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, 5, 5), 1'b0, MISS);
    // drop the background hotspot
    add_row(wr(0, 0, lpp_pkg::KIND_HOTSPOT, 0, 16'sh0000, 1'b0, -32768, -32768, 32767, 32767),
            1'b1, MISS);
    add_row(pk(lpp_pkg::OP_PICK_ALL, -30000, 30000), 1'b0, MISS);

    // hold synchronous reset, then release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) drive_item(directed[i].c, directed[i].fixed, directed[i].res,
                                     $urandom_range(0, 6));
    drain();

    // random items; every third block of 100 runs back to back
    counted = 0;
    seq = 0;
    while (counted < RAND_ITEMS) begin
      c = rand_cmd();
      gap = ((seq / 100) % 3 == 1) ? 0 : $urandom_range(0, 6);
      drive_item(c, 1'b0, MISS, gap);
      counted++;
      seq++;
      if (seq % 300 == 0) drain();
    end
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_hits.size() != 0) report_mismatch("results never seen, count",
                                                   expected_hits.size(), 0);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lpp_pkg.sv
design/lpp_cell.sv
design/layered_point_pick_core.sv
bench/layered_point_pick_core_tb.sv
